>>> rtl/jmci_pkg.sv
`timescale 1ns / 1ps

package jmci_pkg;

	localparam int AXIS_W    = 16;
	localparam int THR_W     = 15;
	localparam int TMO_W     = 8;
	localparam int IDLE_W    = 9;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	localparam logic [THR_W-1:0]  THR_RESET  = 15'd9830;
	localparam logic [TMO_W-1:0]  TMO_RESET  = 8'd5;
	localparam logic [IDLE_W-1:0] IDLE_MAX   = 9'd511;

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 2'd1;

	localparam logic CMD_SAMPLE = 1'b0;
	localparam logic CMD_TICK   = 1'b1;

	typedef enum logic [1:0] {
		ST_NONE = 2'd0,
		ST_INC  = 2'd1,
		ST_DEC  = 2'd2
	} motion_t;

	typedef enum logic [1:0] {
		ACT_STOP_MOVE  = 2'd0,
		ACT_START_MOVE = 2'd1,
		ACT_STOP_ROT   = 2'd2,
		ACT_START_ROT  = 2'd3
	} action_t;

	typedef struct packed {
		action_t action;
		logic    direction;
		logic    last_result;
	} result_t;

	typedef struct packed {
		motion_t            mv_next;
		motion_t            rot_next;
		logic [IDLE_W-1:0]  idle_next;
		logic [1:0]         count;
		result_t            res0;
		result_t            res1;
	} eval_t;

endpackage

>>> rtl/jmci_ifs.sv
`timescale 1ns / 1ps

interface jmci_in_if;
	logic                                valid;
	logic                                ready;
	logic                                command;
	logic signed [jmci_pkg::AXIS_W-1:0]  x_axis;
	logic signed [jmci_pkg::AXIS_W-1:0]  y_axis;

	modport source (output valid, command, x_axis, y_axis, input ready);
	modport sink   (input valid, command, x_axis, y_axis, output ready);
endinterface

interface jmci_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic       direction;
	logic       last_result;

	modport source (output valid, action, direction, last_result, input ready);
	modport sink   (input valid, action, direction, last_result, output ready);
endinterface

interface jmci_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [jmci_pkg::CFG_IDX_W-1:0]      index;
	logic [jmci_pkg::CFG_DAT_W-1:0]      data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/jmci_eval.sv
`timescale 1ns / 1ps

module jmci_eval (
	input  logic                                command,
	input  logic signed [jmci_pkg::AXIS_W-1:0]  x_axis,
	input  logic signed [jmci_pkg::AXIS_W-1:0]  y_axis,
	input  logic [jmci_pkg::THR_W-1:0]          threshold,
	input  logic [jmci_pkg::TMO_W-1:0]          timeout,
	input  jmci_pkg::motion_t                   mv_state,
	input  jmci_pkg::motion_t                   rot_state,
	input  logic [jmci_pkg::IDLE_W-1:0]         idle,
	output jmci_pkg::eval_t                     ev
);

	function automatic jmci_pkg::motion_t classify(
		input logic [jmci_pkg::AXIS_W-1:0] v,
		input logic [jmci_pkg::THR_W-1:0]  thr
	);
		logic [jmci_pkg::AXIS_W:0] mag;
		logic                      neg;
		begin
			neg = v[jmci_pkg::AXIS_W-1];
			mag = neg ? (({1'b1, v} ^ {(jmci_pkg::AXIS_W+1){1'b1}}) + 1'b1) : {1'b0, v};
			if (mag < {2'b00, thr})
				classify = jmci_pkg::ST_NONE;
			else
				classify = neg ? jmci_pkg::ST_DEC : jmci_pkg::ST_INC;
		end
	endfunction

	jmci_pkg::motion_t new_mv;
	jmci_pkg::motion_t new_rot;

	assign new_rot = classify(x_axis, threshold);
	assign new_mv  = classify(y_axis, threshold);

	always_comb begin
		logic              [3:0] flag;
		jmci_pkg::result_t       cand [4];
		jmci_pkg::motion_t       mv_n;
		logic                    mv_chg;
		logic                    rot_chg;
		logic [jmci_pkg::IDLE_W-1:0] idle_inc;

		flag     = '0;
		mv_n     = mv_state;
		mv_chg   = 1'b0;
		rot_chg  = 1'b0;
		idle_inc = (idle < jmci_pkg::IDLE_MAX) ? idle + 1'b1 : idle;

		cand[0] = '{action: jmci_pkg::ACT_STOP_MOVE, direction: 1'b0, last_result: 1'b0};
		cand[1] = '{action: jmci_pkg::ACT_START_MOVE,
			direction: (new_mv == jmci_pkg::ST_DEC), last_result: 1'b0};
		cand[2] = '{action: jmci_pkg::ACT_STOP_ROT, direction: 1'b0, last_result: 1'b0};
		cand[3] = '{action: jmci_pkg::ACT_START_ROT,
			direction: (new_rot == jmci_pkg::ST_DEC), last_result: 1'b0};

		ev = '0;
		ev.mv_next  = mv_state;
		ev.rot_next = rot_state;

		if (command == jmci_pkg::CMD_SAMPLE) begin
			mv_chg  = (mv_state != new_mv);
			mv_n    = new_mv;
			flag[0] = mv_chg && (rot_state == jmci_pkg::ST_NONE) && (mv_state != jmci_pkg::ST_NONE);
			flag[1] = mv_chg && (rot_state == jmci_pkg::ST_NONE) && (new_mv != jmci_pkg::ST_NONE);
			rot_chg = (rot_state != new_rot);
			flag[2] = rot_chg && (mv_n == jmci_pkg::ST_NONE) && (rot_state != jmci_pkg::ST_NONE);
			flag[3] = rot_chg && (mv_n == jmci_pkg::ST_NONE) && (new_rot != jmci_pkg::ST_NONE);
			ev.mv_next   = new_mv;
			ev.rot_next  = new_rot;
			ev.idle_next = '0;
		end else begin
			ev.idle_next = idle_inc;
			if (idle_inc > {1'b0, timeout}) begin
				flag[0]     = (mv_state != jmci_pkg::ST_NONE);
				flag[2]     = (rot_state != jmci_pkg::ST_NONE);
				ev.mv_next  = jmci_pkg::ST_NONE;
				ev.rot_next = jmci_pkg::ST_NONE;
			end
		end

		for (int i = 0; i < 4; i++) begin
			if (flag[i]) begin
				if (ev.count == 2'd0) begin
					ev.res0  = cand[i];
					ev.count = 2'd1;
				end else if (ev.count == 2'd1) begin
					ev.res1  = cand[i];
					ev.count = 2'd2;
				end
			end
		end

		if (ev.count == 2'd1)
			ev.res0.last_result = 1'b1;
		if (ev.count == 2'd2)
			ev.res1.last_result = 1'b1;
	end

endmodule

>>> rtl/jmci_outq.sv
`timescale 1ns / 1ps

module jmci_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  logic [1:0]         count,
	input  jmci_pkg::result_t  res0,
	input  jmci_pkg::result_t  res1,
	output logic               load_ok,
	jmci_out_if.source         out_ch
);

	jmci_pkg::result_t slot0_q;
	jmci_pkg::result_t slot1_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign pop     = out_ch.valid && out_ch.ready;
	assign load_ok = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop);

	assign out_ch.valid       = (cnt_q != 2'd0);
	assign out_ch.action      = slot0_q.action;
	assign out_ch.direction   = slot0_q.direction;
	assign out_ch.last_result = slot0_q.last_result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

`ifndef NO_ASSERTIONS
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("result queue count out of range");
	a_load_room: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && pop)))
		else $error("results loaded over pending items");
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd2) |-> (!slot0_q.last_result && slot1_q.last_result))
		else $error("last marker misplaced in result pair");
`endif

endmodule

>>> rtl/joystick_motion_command_interlock_top.sv
`timescale 1ns / 1ps

// Joystick motion command interlock.
// Channels: in_ch takes items (command 0 = joystick sample with x_axis/y_axis,
// command 1 = one time tick); out_ch gives result items (action, direction,
// last_result), zero to two per input item, the last one marked; cfg writes
// register 0 (motion threshold) and register 1 (timeout in ticks), always ready.
// Path: an accepted item is held in an input register, then its results are
// loaded from there into a two-slot output queue, whose head drives out_ch.
// Items with no result leave the input register and load an empty queue.
// Throughput: one item per cycle while items cause at most one result and the
// receiver takes each result; an item with two results holds the next item in
// the input register, as the single output port drains one result per cycle.
// Reset: threshold 9830, timeout 5, both axes at no motion, idle count zero,
// queue empty. No clearing pass.
// Stall: a stalled receiver holds the queue; the input register then holds its
// item and in_ch.ready drops until the queue has room for two results.
module joystick_motion_command_interlock_top (
	input  logic        clk,
	input  logic        arst_n,
	jmci_in_if.sink     in_ch,
	jmci_out_if.source  out_ch,
	jmci_cfg_if.sink    cfg
);

	logic                                valid_s1;
	logic                                command_s1;
	logic signed [jmci_pkg::AXIS_W-1:0]  x_axis_s1;
	logic signed [jmci_pkg::AXIS_W-1:0]  y_axis_s1;

	logic [jmci_pkg::THR_W-1:0]   threshold_q;
	logic [jmci_pkg::TMO_W-1:0]   timeout_q;
	jmci_pkg::motion_t            mv_state_q;
	jmci_pkg::motion_t            rot_state_q;
	logic [jmci_pkg::IDLE_W-1:0]  idle_q;

	jmci_pkg::eval_t ev;
	logic            load_ok;
	logic            proceed;
	logic            take;

	assign proceed     = valid_s1 && load_ok;
	assign in_ch.ready = !valid_s1 || proceed;
	assign take        = in_ch.valid && in_ch.ready;
	assign cfg.ready   = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			command_s1 <= in_ch.command;
			x_axis_s1  <= in_ch.x_axis;
			y_axis_s1  <= in_ch.y_axis;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= jmci_pkg::THR_RESET;
			timeout_q   <= jmci_pkg::TMO_RESET;
		end else if (cfg.valid && cfg.ready) begin
			if (cfg.index == jmci_pkg::CFG_THRESHOLD)
				threshold_q <= cfg.data[jmci_pkg::THR_W-1:0];
			else if (cfg.index == jmci_pkg::CFG_TIMEOUT)
				timeout_q <= cfg.data[jmci_pkg::TMO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_state_q  <= jmci_pkg::ST_NONE;
			rot_state_q <= jmci_pkg::ST_NONE;
			idle_q      <= '0;
		end else if (proceed) begin
			mv_state_q  <= ev.mv_next;
			rot_state_q <= ev.rot_next;
			idle_q      <= ev.idle_next;
		end
	end

	jmci_eval u_eval (
		.command   (command_s1),
		.x_axis    (x_axis_s1),
		.y_axis    (y_axis_s1),
		.threshold (threshold_q),
		.timeout   (timeout_q),
		.mv_state  (mv_state_q),
		.rot_state (rot_state_q),
		.idle      (idle_q),
		.ev        (ev)
	);

	jmci_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (proceed),
		.count   (ev.count),
		.res0    (ev.res0),
		.res1    (ev.res1),
		.load_ok (load_ok),
		.out_ch  (out_ch)
	);

`ifndef NO_ASSERTIONS
	a_timeout_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && (command_s1 == jmci_pkg::CMD_TICK) && (ev.idle_next > {1'b0, timeout_q}))
		|=> ((mv_state_q == jmci_pkg::ST_NONE) && (rot_state_q == jmci_pkg::ST_NONE)))
		else $error("timeout left a motion active");
	a_sample_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(proceed && (command_s1 == jmci_pkg::CMD_SAMPLE)) |=> (idle_q == '0))
		else $error("sample did not clear idle count");
`endif

endmodule
